/* rtl/qubit_master_equation_rk4_step_unit_defines.svh */
// Assertion macros shared by the checker.
// Each macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef QUBIT_MASTER_EQUATION_RK4_STEP_UNIT_DEFINES_SVH
`define QUBIT_MASTER_EQUATION_RK4_STEP_UNIT_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define QME_AST_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qme assertion failed");

// Consequent holds in the cycle after the antecedent.
`define QME_AST_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qme assertion failed");

// Delayed form: the consequent holds later than the antecedent.
`define QME_AST_DLY2(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##2 (cons)) \
        else $error("qme assertion failed");

`endif

/* rtl/qme_pkg.sv */
`timescale 1ns / 1ps
package qme_pkg;

    // Number format and widths
    localparam int FRAC_BITS  = 30;
    localparam int DW         = 32;
    localparam int SW         = 40;
    localparam int PW         = 64;
    localparam int ACC_W      = 36;
    localparam int SH_W       = 7;
    localparam int DIV_DIGITS = ACC_W / 4;
    localparam int CNT_W      = 4;
    localparam int NUM_EL     = 4;
    localparam int NUM_PMOP   = 8;
    localparam int NUM_MOP    = 12;
    localparam int CFG_IW     = 2;

    typedef logic signed [DW-1:0] t_word;
    typedef logic signed [SW-1:0] t_wide;
    typedef logic signed [PW-1:0] t_prod;

    // Element order of the density matrix
    localparam int EL_EXC = 0;
    localparam int EL_GND = 1;
    localparam int EL_CRE = 2;
    localparam int EL_CIM = 3;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_GM = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_GP = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_BT = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_DT = 2'd3;

    // Multiply operations of one derivative evaluation
    typedef enum logic [3:0] {
        MOP_DRV = 4'd0,
        MOP_GPG = 4'd1,
        MOP_GME = 4'd2,
        MOP_BDF = 4'd3,
        MOP_GMR = 4'd4,
        MOP_GPR = 4'd5,
        MOP_GMI = 4'd6,
        MOP_GPI = 4'd7,
        MOP_KE  = 4'd8,
        MOP_KG  = 4'd9,
        MOP_KR  = 4'd10,
        MOP_KI  = 4'd11
    } t_mop;

    typedef enum logic [1:0] {
        ARG_STATE = 2'd0,
        ARG_HALF  = 2'd1,
        ARG_FULL  = 2'd2
    } t_arg_sel;

    typedef struct packed {
        logic     load_state;
        logic     arg_en;
        t_arg_sel arg_sel;
        logic     diff_en;
        logic     mul_en;
        t_mop     mul_op;
        logic     d_en;
        logic     acc_en;
        logic     acc_clr;
        logic     acc_dbl;
        logic     div_start;
        logic     div_step;
        logic     commit;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_sts;

    localparam t_word WORD_MAX = t_word'({1'b0, {(DW-1){1'b1}}});
    localparam t_word WORD_MIN = t_word'({1'b1, {(DW-1){1'b0}}});
    localparam t_wide WIDE_MAX = t_wide'({{(SW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    localparam t_wide WIDE_MIN = t_wide'({{(SW-DW+1){1'b1}}, {(DW-1){1'b0}}});
    localparam t_prod PROD_MAX = t_prod'({{(PW-DW+1){1'b0}}, {(DW-1){1'b1}}});
    localparam t_prod PROD_MIN = t_prod'({{(PW-DW+1){1'b1}}, {(DW-1){1'b0}}});

    // One in the fixed-point format, clipped when it does not fit
    localparam t_word ONE_Q = (FRAC_BITS >= DW-1) ? WORD_MAX : t_word'(64'd1 << FRAC_BITS);

    function automatic t_wide wext(input t_word v);
        return t_wide'(v);
    endfunction

    function automatic t_word sat_wide(input t_wide v);
        if (v > WIDE_MAX) begin
            return WORD_MAX;
        end else if (v < WIDE_MIN) begin
            return WORD_MIN;
        end
        return v[DW-1:0];
    endfunction

    function automatic t_word sat_prod(input t_prod v);
        if (v > PROD_MAX) begin
            return WORD_MAX;
        end else if (v < PROD_MIN) begin
            return WORD_MIN;
        end
        return v[DW-1:0];
    endfunction

    // Quotient digit of a value below 96 divided by six
    function automatic logic [3:0] div6_digit(input logic [6:0] v);
        logic [3:0] d;
        d = '0;
        for (int j = 1; j < 16; j++) begin
            if (v >= 7'(6 * j)) begin
                d = 4'(j);
            end
        end
        return d;
    endfunction

endpackage

/* rtl/qme_in_if.sv */
`timescale 1ns / 1ps
interface qme_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic        [30:0] load_excited;
    logic        [30:0] load_ground;
    logic signed [30:0] load_coh_real;
    logic signed [30:0] load_coh_imag;

    modport source (output valid, mode, load_excited, load_ground, load_coh_real,
                    load_coh_imag, input ready);
    modport sink (input valid, mode, load_excited, load_ground, load_coh_real,
                  load_coh_imag, output ready);
endinterface

/* rtl/qme_out_if.sv */
`timescale 1ns / 1ps
interface qme_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] excited_pop;
    logic signed [31:0] ground_pop;
    logic signed [31:0] coh_real;
    logic signed [31:0] coh_imag;
    logic signed [31:0] z_expect;
    logic signed [31:0] x_expect;

    modport source (output valid, excited_pop, ground_pop, coh_real, coh_imag,
                    z_expect, x_expect, input ready);
    modport sink (input valid, excited_pop, ground_pop, coh_real, coh_imag,
                  z_expect, x_expect, output ready);
endinterface

/* rtl/qme_ctrl.sv */
`timescale 1ns / 1ps
module qme_ctrl import qme_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_mode,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_ARG    = 12'b0000_0000_0010,
        S_DIFF   = 12'b0000_0000_0100,
        S_PMUL   = 12'b0000_0000_1000,
        S_PWB    = 12'b0000_0001_0000,
        S_DCALC  = 12'b0000_0010_0000,
        S_KMUL   = 12'b0000_0100_0000,
        S_KWB    = 12'b0000_1000_0000,
        S_ACC    = 12'b0001_0000_0000,
        S_DIV    = 12'b0010_0000_0000,
        S_COMMIT = 12'b0100_0000_0000,
        S_OUT    = 12'b1000_0000_0000
    } t_state;

    t_state           r_state, n_state;
    logic [1:0]       r_stage, n_stage;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // Advance the sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_stage <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_stage <= n_stage;
            r_cnt   <= n_cnt;
        end
    end

    // Decode state into datapath commands
    always_comb begin
        n_state    = r_state;
        n_stage    = r_stage;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_cmd.arg_sel = ARG_STATE;
        o_cmd.mul_op  = MOP_DRV;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    if (i_in_mode) begin
                        o_cmd.load_state = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_stage = '0;
                        n_state = S_ARG;
                    end
                end
            end
            S_ARG: begin
                o_cmd.arg_en = 1'b1;
                case (r_stage)
                    2'd0:    o_cmd.arg_sel = ARG_STATE;
                    2'd3:    o_cmd.arg_sel = ARG_FULL;
                    default: o_cmd.arg_sel = ARG_HALF;
                endcase
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff_en = 1'b1;
                n_cnt   = '0;
                n_state = S_PMUL;
            end
            S_PMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = t_mop'(r_cnt);
                if (r_cnt == CNT_W'(NUM_PMOP - 1)) begin
                    n_cnt   = '0;
                    n_state = S_PWB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_PWB: begin
                n_state = S_DCALC;
            end
            S_DCALC: begin
                o_cmd.d_en = 1'b1;
                n_cnt   = '0;
                n_state = S_KMUL;
            end
            S_KMUL: begin
                o_cmd.mul_en = 1'b1;
                o_cmd.mul_op = t_mop'(CNT_W'(NUM_PMOP) + r_cnt);
                if (r_cnt == CNT_W'(NUM_MOP - NUM_PMOP - 1)) begin
                    n_cnt   = '0;
                    n_state = S_KWB;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_KWB: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc_en  = 1'b1;
                o_cmd.acc_clr = (r_stage == 2'd0);
                o_cmd.acc_dbl = (r_stage == 2'd1) || (r_stage == 2'd2);
                if (r_stage == 2'd3) begin
                    n_cnt   = '0;
                    n_state = S_DIV;
                end else begin
                    n_stage = r_stage + 1'b1;
                    n_state = S_ARG;
                end
            end
            S_DIV: begin
                if (r_cnt == '0) begin
                    o_cmd.div_start = 1'b1;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
                if (r_cnt == CNT_W'(DIV_DIGITS)) begin
                    n_state = S_COMMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/qme_dp.sv */
`timescale 1ns / 1ps
module qme_dp import qme_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  logic               i_cfg_we,
    input  logic [CFG_IW-1:0]  i_cfg_idx,
    input  logic [DW-1:0]      i_cfg_data,
    input  logic [30:0]        i_load_excited,
    input  logic [30:0]        i_load_ground,
    input  logic signed [30:0] i_load_coh_real,
    input  logic signed [30:0] i_load_coh_imag,
    qme_out_if.source          o_out
);

    // Configuration
    logic [30:0] r_gm, r_gp, r_dt;
    t_word       r_bt;

    // State, stage arguments and intermediates
    t_word r_st [NUM_EL];
    t_word r_a  [NUM_EL];
    t_word r_d  [NUM_EL];
    t_word r_pv [NUM_MOP];
    t_word r_diff;

    // Multiplier pipeline
    t_prod r_prod;
    logic  r_wb_vld;
    t_mop  r_wb_op;

    // Increment accumulation and division by six
    logic signed [ACC_W-1:0] r_acc [NUM_EL];
    logic [ACC_W-1:0]        r_dq  [NUM_EL];
    logic [2:0]              r_rem [NUM_EL];
    logic                    r_neg [NUM_EL];

    // Output register
    logic  r_out_vld;
    t_word r_o_exc, r_o_gnd, r_o_cre, r_o_cim, r_o_z, r_o_x;

    t_word             w_ma, w_mb;
    logic [SH_W-1:0]   w_sh;
    t_prod             w_half, w_rnd, w_shr;
    t_word             w_wb;
    t_word             w_arg [NUM_EL];
    logic [6:0]        w_dv  [NUM_EL];
    logic [3:0]        w_dg  [NUM_EL];
    logic [ACC_W-1:0]  w_mag [NUM_EL];
    t_wide             w_q   [NUM_EL];

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gm <= 31'd1073741824;
            r_gp <= 31'd0;
            r_bt <= 32'sd214748365;
            r_dt <= 31'd1073742;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GM:  r_gm <= i_cfg_data[30:0];
                CFG_GP:  r_gp <= i_cfg_data[30:0];
                CFG_BT:  r_bt <= t_word'(i_cfg_data);
                CFG_DT:  r_dt <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // Stage argument: state plus none, half or all of the previous k
    always_comb begin
        for (int e = 0; e < NUM_EL; e++) begin
            case (i_cmd.arg_sel)
                ARG_HALF: w_arg[e] = sat_wide(wext(r_st[e])
                                     + ((wext(r_pv[NUM_PMOP + e]) + t_wide'(1)) >>> 1));
                ARG_FULL: w_arg[e] = sat_wide(wext(r_st[e]) + wext(r_pv[NUM_PMOP + e]));
                default:  w_arg[e] = r_st[e];
            endcase
        end
    end

    // Operand selection for the shared multiplier
    always_comb begin
        case (i_cmd.mul_op)
            MOP_DRV: begin w_ma = r_bt;              w_mb = r_a[EL_CRE]; end
            MOP_GPG: begin w_ma = t_word'({1'b0, r_gp}); w_mb = r_a[EL_GND]; end
            MOP_GME: begin w_ma = t_word'({1'b0, r_gm}); w_mb = r_a[EL_EXC]; end
            MOP_BDF: begin w_ma = r_bt;              w_mb = r_diff;      end
            MOP_GMR: begin w_ma = t_word'({1'b0, r_gm}); w_mb = r_a[EL_CRE]; end
            MOP_GPR: begin w_ma = t_word'({1'b0, r_gp}); w_mb = r_a[EL_CRE]; end
            MOP_GMI: begin w_ma = t_word'({1'b0, r_gm}); w_mb = r_a[EL_CIM]; end
            MOP_GPI: begin w_ma = t_word'({1'b0, r_gp}); w_mb = r_a[EL_CIM]; end
            MOP_KE:  begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_d[EL_EXC]; end
            MOP_KG:  begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_d[EL_GND]; end
            MOP_KR:  begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_d[EL_CRE]; end
            default: begin w_ma = t_word'({1'b0, r_dt}); w_mb = r_d[EL_CIM]; end
        endcase
    end

    // Rounding shift of the registered product
    always_comb begin
        case (r_wb_op)
            MOP_DRV:                            w_sh = SH_W'(FRAC_BITS - 1);
            MOP_GMR, MOP_GPR, MOP_GMI, MOP_GPI: w_sh = SH_W'(FRAC_BITS + 1);
            default:                            w_sh = SH_W'(FRAC_BITS);
        endcase
        w_half = t_prod'(PW'(1) << (w_sh - 1'b1));
        w_rnd  = r_prod + w_half;
        w_shr  = w_rnd >>> w_sh;
        w_wb   = sat_prod(w_shr);
    end

    // Digit step and sign handling of the division by six
    always_comb begin
        for (int e = 0; e < NUM_EL; e++) begin
            w_dv[e]  = {r_rem[e], r_dq[e][ACC_W-1 -: 4]};
            w_dg[e]  = div6_digit(w_dv[e]);
            w_mag[e] = r_acc[e][ACC_W-1] ? ACC_W'(-r_acc[e]) : ACC_W'(r_acc[e]);
            w_q[e]   = r_neg[e] ? -t_wide'(r_dq[e]) : t_wide'(r_dq[e]);
        end
    end

    // Multiplier pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb_vld <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.mul_en;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod  <= t_prod'(w_ma) * t_prod'(w_mb);
            r_wb_op <= i_cmd.mul_op;
        end
        if (r_wb_vld) begin
            r_pv[r_wb_op] <= w_wb;
        end
        if (i_cmd.arg_en) begin
            for (int e = 0; e < NUM_EL; e++) begin
                r_a[e] <= w_arg[e];
            end
        end
        if (i_cmd.diff_en) begin
            r_diff <= sat_wide(wext(r_a[EL_EXC]) - wext(r_a[EL_GND]));
        end
        if (i_cmd.d_en) begin
            r_d[EL_EXC] <= sat_wide(wext(r_pv[MOP_GPG]) - wext(r_pv[MOP_GME])
                                    - wext(r_pv[MOP_DRV]));
            r_d[EL_GND] <= sat_wide(wext(r_pv[MOP_GME]) - wext(r_pv[MOP_GPG])
                                    + wext(r_pv[MOP_DRV]));
            r_d[EL_CRE] <= sat_wide(wext(r_pv[MOP_BDF]) - wext(r_pv[MOP_GMR])
                                    - wext(r_pv[MOP_GPR]));
            r_d[EL_CIM] <= sat_wide(-wext(r_pv[MOP_GMI]) - wext(r_pv[MOP_GPI]));
        end
        for (int e = 0; e < NUM_EL; e++) begin
            if (i_cmd.acc_en) begin
                r_acc[e] <= (i_cmd.acc_clr ? '0 : r_acc[e])
                            + (ACC_W'(r_pv[NUM_PMOP + e]) <<< (i_cmd.acc_dbl ? 1 : 0));
            end
            if (i_cmd.div_start) begin
                r_dq[e]  <= w_mag[e] + ACC_W'(3);
                r_rem[e] <= '0;
                r_neg[e] <= r_acc[e][ACC_W-1];
            end else if (i_cmd.div_step) begin
                r_dq[e]  <= {r_dq[e][ACC_W-5:0], w_dg[e]};
                r_rem[e] <= 3'(w_dv[e] - 7'(w_dg[e]) * 7'd6);
            end
        end
    end

    // State update: reset, load or committed RK4 step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st[EL_EXC] <= '0;
            r_st[EL_GND] <= ONE_Q;
            r_st[EL_CRE] <= '0;
            r_st[EL_CIM] <= '0;
        end else if (i_cmd.load_state) begin
            r_st[EL_EXC] <= t_word'({1'b0, i_load_excited});
            r_st[EL_GND] <= t_word'({1'b0, i_load_ground});
            r_st[EL_CRE] <= t_word'(i_load_coh_real);
            r_st[EL_CIM] <= t_word'(i_load_coh_imag);
        end else if (i_cmd.commit) begin
            for (int e = 0; e < NUM_EL; e++) begin
                r_st[e] <= sat_wide(wext(r_st[e]) + w_q[e]);
            end
        end
    end

    // Output register: hold the request until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_o_exc <= r_st[EL_EXC];
            r_o_gnd <= r_st[EL_GND];
            r_o_cre <= r_st[EL_CRE];
            r_o_cim <= r_st[EL_CIM];
            r_o_z   <= sat_wide(wext(r_st[EL_EXC]) - wext(r_st[EL_GND]));
            r_o_x   <= sat_wide(wext(r_st[EL_CRE]) + wext(r_st[EL_CRE]));
        end
    end

    assign o_sts.out_free    = !r_out_vld || o_out.ready;
    assign o_out.valid       = r_out_vld;
    assign o_out.excited_pop = r_o_exc;
    assign o_out.ground_pop  = r_o_gnd;
    assign o_out.coh_real    = r_o_cre;
    assign o_out.coh_imag    = r_o_cim;
    assign o_out.z_expect    = r_o_z;
    assign o_out.x_expect    = r_o_x;

endmodule

/* rtl/qubit_master_equation_rk4_step_unit.sv */
`timescale 1ns / 1ps
// Advance request: four derivative stages on the single shared multiplier, then radix-16
// division by six, commit and output load into the result register; a load request
// goes straight to the output load.
// Throughput: one request at a time; the next is accepted once the controller is idle.
// Reset (synchronous, active low) restores the default rates and the ground state.
module qubit_master_equation_rk4_step_unit import qme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qme_in_if.sink            i_in,
    qme_out_if.source         o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [DW-1:0]     i_cfg_data
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    qme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_mode  (i_in.mode),
        .o_in_ready (w_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    qme_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_load_excited  (i_in.load_excited),
        .i_load_ground   (i_in.load_ground),
        .i_load_coh_real (i_in.load_coh_real),
        .i_load_coh_imag (i_in.load_coh_imag),
        .o_out           (o_out)
    );

endmodule

/* rtl/qme_checker.sv */
`timescale 1ns / 1ps
`include "qubit_master_equation_rk4_step_unit_defines.svh"
module qme_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_in_mode,
    input logic i_out_valid,
    input logic i_out_ready
);

    // a pending result request stays up until taken
    `QME_AST_NXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // one request at a time: drop ready after an acceptance
    `QME_AST_NXT(a_in_busy, i_in_valid && i_in_ready, !i_in_ready)
    // a new result appears only as the unit returns to idle
    `QME_AST_IMP(a_out_idle, $rose(i_out_valid), i_in_ready)
    // a load with a free output slot is answered once the output register is loaded
    `QME_AST_DLY2(a_load_lat, i_in_valid && i_in_ready && i_in_mode && !i_out_valid,
                  i_out_valid)

endmodule

bind qubit_master_equation_rk4_step_unit qme_checker u_qme_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_mode   (i_in.mode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready)
);
